>>> rtl/msdf_pkg.sv
// ============================================================================
// msdf_pkg
// Shared types and constants of the stepped dimmer fade core.
// ============================================================================
package msdf_pkg;

    // Item opcodes
    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_MAX_STEP       = 2'd0;
    localparam logic [1:0] REG_MAX_BRIGHTNESS = 2'd1;
    localparam logic [1:0] REG_STEP_SIZE      = 2'd2;
    localparam logic [1:0] REG_SMOOTH_MASK    = 2'd3;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // A tick reports at most this many channels
    localparam int MAX_RESULTS = 8;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic [7:0]  max_step;
        logic [15:0] max_brightness;
        logic [15:0] step_size;
        logic [7:0]  smooth_mask;
    } t_cfg;

    typedef struct packed {
        logic        enabled;
        logic [7:0]  step;
        logic [15:0] current;
        logic [15:0] target;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{enabled: 1'b0, step: 8'd1,
                                       current: 16'd0, target: 16'd0};

    typedef struct packed {
        logic [2:0]  channel;
        logic [15:0] level;
        logic        notify;
        logic        enabled;
        logic [7:0]  step;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CALC,
        S_FLUSH
    } t_state;

endpackage

>>> rtl/msdf_ram.sv
// ============================================================================
// msdf_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module msdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/msdf_regs.sv
// ============================================================================
// msdf_regs
// APB configuration registers of the dimmer core.
// ============================================================================
module msdf_regs
    import msdf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_step       <= 8'd255;
            r_cfg.max_brightness <= 16'd65535;
            r_cfg.step_size      <= 16'd257;
            r_cfg.smooth_mask    <= 8'd0;
        end else if (w_wr) begin
            case (w_idx)
                REG_MAX_STEP:       r_cfg.max_step       <= pwdata[7:0];
                REG_MAX_BRIGHTNESS: r_cfg.max_brightness <= pwdata[15:0];
                REG_STEP_SIZE:      r_cfg.step_size      <= pwdata[15:0];
                REG_SMOOTH_MASK:    r_cfg.smooth_mask    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MAX_STEP:       prdata = {24'd0, r_cfg.max_step};
            REG_MAX_BRIGHTNESS: prdata = {16'd0, r_cfg.max_brightness};
            REG_STEP_SIZE:      prdata = {16'd0, r_cfg.step_size};
            REG_SMOOTH_MASK:    prdata = {24'd0, r_cfg.smooth_mask};
            default:            prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/msdf_level.sv
// ============================================================================
// msdf_level
// Step clamp and target level lookup, registered after the multiply.
// ============================================================================
module msdf_level
    import msdf_pkg::*;
(
    input  logic        i_clk,
    input  logic [7:0]  i_step,
    input  t_cfg        i_cfg,
    output logic [7:0]  o_step_clamped,
    output logic [15:0] o_level
);

    logic [7:0]  w_sc;
    logic [23:0] w_prod;
    logic [15:0] w_level;
    logic [7:0]  r_sc;
    logic [15:0] r_level;

    assign w_sc   = (i_step > i_cfg.max_step) ? i_cfg.max_step : i_step;
    assign w_prod = 24'(i_cfg.step_size) * 24'(w_sc);

    always_comb begin
        if (w_sc == 8'd0) begin
            w_level = 16'd0;
        end else if (w_sc >= i_cfg.max_step) begin
            w_level = i_cfg.max_brightness;
        end else if (w_prod[23:16] != 8'd0) begin
            w_level = 16'hFFFF;   // saturate
        end else begin
            w_level = w_prod[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sc    <= w_sc;
        r_level <= w_level;
    end

    assign o_step_clamped = r_sc;
    assign o_level        = r_level;

endmodule

>>> rtl/multichannel_stepped_dimmer_fade_core.sv
// ============================================================================
// multichannel_stepped_dimmer_fade_core
// Per-channel stepped dimmer with a one-count-per-tick linear fade.
// ============================================================================
//
//  Channel  Direction  Handshake                 Beat
//  -------  ---------  ------------------------  ---------------------------------
//  in       sink       i_in_valid / o_in_ready   op, channel, step_level
//  out      source     o_out_valid / i_out_ready channel, drive level, flags, last
//  apb      slave      psel/penable, pready      one 32-bit register write or read
//
//  A set beat passes through accept, RAM read, modify and write back, and flush
//  of the result. A tick beat walks all channels, a read and then a modify/write
//  for each channel, between accept and flush.
//  Reset clears control state only; the channel RAM is not swept. A per-entry
//  valid flop makes a never-written channel read as its reset value.
//  The walk stalls only when a second result is ready while both the hold
//  stage and the output register are full.
// ============================================================================
module multichannel_stepped_dimmer_fade_core
    import msdf_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_op,
    input  logic [2:0]         i_channel,
    input  logic [7:0]         i_step_level,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_out_channel,
    output logic [15:0]        o_drive_level,
    output logic               o_notify,
    output logic               o_channel_enabled,
    output logic [7:0]         o_channel_step,
    output logic               o_last,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ENTRY_W = $bits(t_entry);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state              r_state, n_state;
    logic                r_op;
    logic [2:0]          r_ch;
    logic [7:0]          r_step;
    logic [CH_W-1:0]     r_idx;
    logic [NRES_W-1:0]   r_nres;
    logic [CHANNELS-1:0] r_init;      // entry has been written since reset
    logic                r_rd_init;   // valid flag of the entry being read
    logic                r_hold_valid;
    t_result             r_hold;
    logic                r_out_valid;
    t_result             r_out;
    logic                r_out_last;

    // ------------------------------------------------------------------
    // Submodules
    // ------------------------------------------------------------------
    t_cfg                w_cfg;
    logic [7:0]          w_step_clamped;
    logic [15:0]         w_level;
    logic [ENTRY_W-1:0]  w_rdata;
    logic                w_ram_re;
    logic                w_ram_we;
    t_entry              w_ram_wdata;
    logic [CH_W-1:0]     w_ram_addr;

    msdf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Target level is registered from the captured step and is ready in the CALC state.
    msdf_level u_level (
        .i_clk          (i_clk),
        .i_step         (r_step),
        .i_cfg          (w_cfg),
        .o_step_clamped (w_step_clamped),
        .o_level        (w_level)
    );

    msdf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_addr),
        .o_rdata (w_rdata)
    );

    assign w_ram_addr = r_idx;

    // ------------------------------------------------------------------
    // Datapath of the modify step
    // ------------------------------------------------------------------
    logic    w_in_acc;
    logic    w_in_drop;
    logic    w_out_free;
    logic    w_smooth;
    logic    w_moving;
    logic    w_blocked;
    logic    w_last_idx;
    t_entry  w_cur;
    t_entry  w_set_entry;
    t_entry  w_tick_entry;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid & o_in_ready;
    // A set beat for a channel that does not exist is dropped
    assign w_in_drop  = (i_op == OP_SET) && (int'(i_channel) >= CHANNELS);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_smooth   = w_cfg.smooth_mask[r_ch];
    assign w_last_idx = (r_idx == CH_W'(CHANNELS - 1));

    assign w_cur = r_rd_init ? t_entry'(w_rdata) : ENTRY_RESET;

    always_comb begin
        w_set_entry = w_cur;
        if (r_step == 8'd0) begin
            // off: keep the last active step
            w_set_entry.enabled = 1'b0;
            w_set_entry.target  = 16'd0;
        end else begin
            w_set_entry.enabled = 1'b1;
            w_set_entry.step    = w_step_clamped;
            w_set_entry.target  = w_level;
        end
        if (!w_smooth) begin
            w_set_entry.current = w_set_entry.target;
        end
    end

    always_comb begin
        w_tick_entry = w_cur;
        if (w_cur.current < w_cur.target) begin
            w_tick_entry.current = w_cur.current + 16'd1;
        end else begin
            w_tick_entry.current = w_cur.current - 16'd1;
        end
    end

    assign w_moving  = (w_cur.current != w_cur.target) &&
                       (r_nres != NRES_W'(MAX_RESULTS));
    // A new result needs the hold stage; hold can drain only into a free output
    assign w_blocked = w_moving && r_hold_valid && !w_out_free;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && !w_in_drop) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                if (r_op == OP_SET) begin
                    n_state = S_FLUSH;
                end else if (!w_blocked) begin
                    n_state = w_last_idx ? S_FLUSH : S_READ;
                end
            end
            S_FLUSH: begin
                if (!r_hold_valid || w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // State outputs
    // ------------------------------------------------------------------
    logic    w_push;
    logic    w_push_last;
    logic    w_hold_load;
    t_result w_hold_data;
    logic    w_advance;
    logic    w_count;

    always_comb begin
        w_ram_re    = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_wdata = w_set_entry;
        w_push      = 1'b0;
        w_push_last = 1'b0;
        w_hold_load = 1'b0;
        w_hold_data = '{channel: 3'(r_idx), level: w_set_entry.current,
                        notify: 1'b1, enabled: w_set_entry.enabled,
                        step: w_set_entry.step};
        w_advance   = 1'b0;
        w_count     = 1'b0;
        case (r_state)
            S_READ: begin
                w_ram_re = 1'b1;
            end
            S_CALC: begin
                if (r_op == OP_SET) begin
                    w_ram_we    = 1'b1;
                    w_hold_load = !w_smooth;
                end else begin
                    w_ram_wdata = w_tick_entry;
                    w_hold_data = '{channel: 3'(r_idx),
                                    level: w_tick_entry.current,
                                    notify: (w_tick_entry.current == w_tick_entry.target),
                                    enabled: w_tick_entry.enabled,
                                    step: w_tick_entry.step};
                    if (w_moving && !w_blocked) begin
                        w_ram_we    = 1'b1;
                        w_hold_load = 1'b1;
                        w_push      = r_hold_valid;   // drain previous result
                        w_count     = 1'b1;
                    end
                    w_advance = !w_blocked && !w_last_idx;
                end
            end
            S_FLUSH: begin
                // final result of the item goes out with last set
                w_push      = r_hold_valid && w_out_free;
                w_push_last = 1'b1;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequential
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_nres       <= '0;
            r_init       <= '0;
            r_rd_init    <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_in_acc) begin
                r_idx  <= (i_op == OP_TICK) ? '0 : CH_W'(i_channel);
                r_nres <= '0;
            end else if (w_advance) begin
                r_idx <= r_idx + CH_W'(1);
            end

            if (w_count) begin
                r_nres <= r_nres + NRES_W'(1);
            end

            if (w_ram_re) begin
                r_rd_init <= r_init[r_idx];
            end

            if (w_ram_we) begin
                r_init[r_idx] <= 1'b1;
            end

            if (w_hold_load) begin
                r_hold_valid <= 1'b1;
            end else if (w_push) begin
                r_hold_valid <= 1'b0;
            end

            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op   <= i_op;
            r_ch   <= i_channel;
            r_step <= i_step_level;
        end
        if (w_hold_load) begin
            r_hold <= w_hold_data;
        end
        if (w_push) begin
            r_out      <= r_hold;
            r_out_last <= w_push_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_channel     = r_out.channel;
    assign o_drive_level     = r_out.level;
    assign o_notify          = r_out.notify;
    assign o_channel_enabled = r_out.enabled;
    assign o_channel_step    = r_out.step;
    assign o_last            = r_out_last;

endmodule
